// File: sv/tft_pkg.sv
// Shared types and constants for the TCP flow tracker.
package tft_pkg;

  localparam int unsigned Buckets    = 256;
  localparam int unsigned Ways       = 4;
  localparam int unsigned Entries    = Buckets * Ways;
  localparam int unsigned BucketW    = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned WayW       = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned EntryW     = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned EntryCntW  = $clog2(Entries + 1);
  localparam logic [15:0] HashLoMask = 16'h00ff;

  typedef enum logic [2:0] {
    KIND_UPDATED = 3'd0,
    KIND_INSERTED = 3'd1,
    KIND_CLOSED = 3'd2,
    KIND_DRAINED = 3'd3,
    KIND_FULL = 3'd4,
    KIND_EMPTY = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_EST = 3'd0,
    ST_FW1 = 3'd1,
    ST_FW2 = 3'd2,
    ST_TW = 3'd3,
    ST_CW = 3'd4,
    ST_LA = 3'd5,
    ST_CLOSED = 3'd6
  } conn_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
    logic        fin_flag;
    logic        ack_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] rec_src_ip;
    logic [31:0] rec_dst_ip;
    logic [15:0] rec_src_port;
    logic [15:0] rec_dst_port;
    logic [31:0] rec_up_bytes;
    logic [31:0] rec_down_bytes;
    logic [31:0] rec_up_pkts;
    logic [31:0] rec_down_pkts;
    logic [2:0]  rec_state;
  } rsp_t;

  // flow entry as stored (valid kept in its own memory)
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] up_bytes;
    logic [31:0] down_bytes;
    logic [31:0] up_pkts;
    logic [31:0] down_pkts;
    logic [2:0]  conn_state;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // capture request
    logic mul_step;   // register product
    logic hash_step;  // register bucket
    logic rd_way;     // read entry at bucket/way_idx
    logic eval_way;   // compare the read entry
    logic rd_drain;   // read entry at scan pointer
    logic wr_update;  // write updated entry
    logic wr_insert;  // write new entry at free way
    logic clr;        // valid write at scan pointer (clearing pass)
    logic vld_we;     // write one valid bit
    logic vld_wd;     // valid bit value
    logic out_load;   // load result hold register from rsp_next
    logic out_push;   // move held result into the output register
    logic [WayW-1:0] way_idx;
    logic [2:0] kind;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic closes;
    logic vld;
  } dp_sts_t;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

endpackage

// File: sv/tft_if.sv
// Valid/ready channel carrying one word.
interface tft_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/tft_datapath.sv
// Flow table datapath: hash, entry memory, way compare, update and result build.
module tft_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tft_pkg::req_t     req_i,
  input  tft_pkg::dp_cmd_t  cmd_i,
  input  logic [tft_pkg::EntryW-1:0] drain_idx_i,
  output tft_pkg::dp_sts_t  sts_o,
  output tft_pkg::rsp_t     rsp_o
);
  import tft_pkg::*;

  entry_t mem_q [Entries];
  logic   vld_mem_q [Entries];
  entry_t rd_q;
  logic   rd_vld_q;
  req_t   req_q;
  logic [31:0] prod_q;
  logic [BucketW-1:0] bucket_q;
  logic [EntryW-1:0] addr_q;
  logic [EntryW-1:0] rd_addr;
  logic [EntryW-1:0] way_addr;
  logic [EntryW-1:0] vld_addr;
  logic [31:0] r;
  logic [15:0] h;
  logic up, down, hit;
  entry_t upd;
  conn_e st;
  rsp_t rsp_next;
  rsp_t rsp_hold_q;

  assign way_addr = EntryW'({bucket_q, cmd_i.way_idx});

  always_comb begin
    r = req_q.src_ip ^ req_q.dst_ip ^ prod_q;
    h = (r[15:0] & HashLoMask) ^ r[31:16];
  end

  always_comb begin
    if (cmd_i.rd_drain) begin
      rd_addr = drain_idx_i;
    end else begin
      rd_addr = way_addr;
    end
  end

  always_comb begin
    if (cmd_i.clr) begin
      vld_addr = drain_idx_i;
    end else if (cmd_i.wr_insert) begin
      vld_addr = way_addr;
    end else begin
      vld_addr = addr_q;
    end
  end

  always_comb begin
    up = rd_q.src_ip == req_q.src_ip && rd_q.dst_ip == req_q.dst_ip &&
         rd_q.src_port == req_q.src_port && rd_q.dst_port == req_q.dst_port;
    down = rd_q.src_ip == req_q.dst_ip && rd_q.dst_ip == req_q.src_ip &&
           rd_q.src_port == req_q.dst_port && rd_q.dst_port == req_q.src_port;
    hit = rd_vld_q && (up || down);
    upd = rd_q;
    st = conn_e'(rd_q.conn_state);
    if (up) begin
      upd.up_bytes = sat_add(rd_q.up_bytes, {16'd0, req_q.payload_len});
      upd.up_pkts = sat_add(rd_q.up_pkts, 32'd1);
      if (st == ST_EST && req_q.fin_flag) st = ST_FW1;
      else if (st == ST_TW && req_q.ack_flag) st = ST_CLOSED;
      else if (st == ST_CW && req_q.fin_flag) st = ST_LA;
    end else begin
      upd.down_bytes = sat_add(rd_q.down_bytes, {16'd0, req_q.payload_len});
      upd.down_pkts = sat_add(rd_q.down_pkts, 32'd1);
      if (st == ST_EST && req_q.fin_flag) st = ST_CW;
      else if (st == ST_LA && req_q.ack_flag) st = ST_CLOSED;
      else if (st == ST_FW1 && req_q.ack_flag) st = ST_FW2;
      else if (st == ST_FW2 && req_q.fin_flag) st = ST_TW;
    end
    upd.conn_state = st;
  end

  assign sts_o.hit = hit;
  assign sts_o.closes = (upd.conn_state == ST_CLOSED);
  assign sts_o.vld = rd_vld_q;

  // new flow entry
  entry_t ins;
  always_comb begin
    ins = '0;
    ins.src_ip = req_q.src_ip;
    ins.dst_ip = req_q.dst_ip;
    ins.src_port = req_q.src_port;
    ins.dst_port = req_q.dst_port;
    ins.up_bytes = {16'd0, req_q.payload_len};
    ins.up_pkts = 32'd1;
    ins.conn_state = ST_EST;
  end

  always_comb begin
    entry_t e;
    e = '0;
    unique case (kind_e'(cmd_i.kind))
      KIND_UPDATED, KIND_CLOSED: e = upd;
      KIND_INSERTED: e = ins;
      KIND_DRAINED: e = rd_q;
      KIND_FULL: begin
        e.src_ip = req_q.src_ip;
        e.dst_ip = req_q.dst_ip;
        e.src_port = req_q.src_port;
        e.dst_port = req_q.dst_port;
      end
      default: e = '0;
    endcase
    rsp_next.out_kind = cmd_i.kind;
    rsp_next.rec_src_ip = e.src_ip;
    rsp_next.rec_dst_ip = e.dst_ip;
    rsp_next.rec_src_port = e.src_port;
    rsp_next.rec_dst_port = e.dst_port;
    rsp_next.rec_up_bytes = e.up_bytes;
    rsp_next.rec_down_bytes = e.down_bytes;
    rsp_next.rec_up_pkts = e.up_pkts;
    rsp_next.rec_down_pkts = e.down_pkts;
    rsp_next.rec_state = e.conn_state;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.mul_step) prod_q <= 32'(req_q.src_port * req_q.dst_port);
    if (cmd_i.hash_step) bucket_q <= h[BucketW-1:0];
    if (cmd_i.rd_way || cmd_i.rd_drain) begin
      rd_q <= mem_q[rd_addr];
      rd_vld_q <= vld_mem_q[rd_addr];
      addr_q <= rd_addr;
    end
    if (cmd_i.wr_update) mem_q[addr_q] <= upd;
    if (cmd_i.wr_insert) mem_q[way_addr] <= ins;
    if (cmd_i.vld_we) vld_mem_q[vld_addr] <= cmd_i.vld_wd;
    if (cmd_i.out_load) rsp_hold_q <= rsp_next;
    if (cmd_i.out_push) rsp_o <= rsp_hold_q;
  end

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

// File: sv/tft_ctrl.sv
// Flow tracker sequencer: clearing pass, bucket walk, drain scan and handshakes.
module tft_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tft_pkg::dp_sts_t sts_i,
  output tft_pkg::dp_cmd_t cmd_o,
  output logic [tft_pkg::EntryW-1:0] drain_idx_o
);
  import tft_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_HASH, S_READ, S_EVAL, S_SCAN, S_SCHK, S_DONE
  } state_e;

  state_e state_q;
  logic [EntryW-1:0] cursor_q, scan_q;
  logic [EntryCntW-1:0] cnt_q;
  logic [WayW:0] way_q;
  logic [WayW:0] free_q;
  logic out_valid_q, out_valid_d;
  logic [EntryW-1:0] scan_nx;

  assign drain_idx_o = scan_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign scan_nx = (scan_q == EntryW'(Entries - 1)) ? '0 : scan_q + 1'b1;

  always_comb begin
    cmd_o = '0;
    cmd_o.way_idx = way_q[WayW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        cmd_o.vld_we = 1'b1;
      end
      S_IDLE: cmd_o.load_req = in_valid_i;
      S_MUL: cmd_o.mul_step = 1'b1;
      S_HASH: cmd_o.hash_step = 1'b1;
      S_READ: cmd_o.rd_way = 1'b1;
      S_EVAL: begin
        if (sts_i.hit) begin
          cmd_o.wr_update = 1'b1;
          cmd_o.vld_we = 1'b1;
          cmd_o.vld_wd = !sts_i.closes;
          cmd_o.out_load = 1'b1;
          cmd_o.kind = sts_i.closes ? KIND_CLOSED : KIND_UPDATED;
        end else if (way_q == (WayW+1)'(Ways - 1)) begin
          cmd_o.out_load = 1'b1;
          if (free_q != (WayW+1)'(Ways) || !sts_i.vld) begin
            cmd_o.wr_insert = 1'b1;
            cmd_o.vld_we = 1'b1;
            cmd_o.vld_wd = 1'b1;
            cmd_o.kind = KIND_INSERTED;
            cmd_o.way_idx = (free_q != (WayW+1)'(Ways)) ? free_q[WayW-1:0]
                                                       : way_q[WayW-1:0];
          end else begin
            cmd_o.kind = KIND_FULL;
          end
        end
      end
      S_SCAN: cmd_o.rd_drain = 1'b1;
      S_SCHK: begin
        if (sts_i.vld) begin
          cmd_o.vld_we = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.kind = KIND_DRAINED;
        end else if (cnt_q == EntryCntW'(Entries - 1)) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind = KIND_EMPTY;
        end
      end
      S_DONE: cmd_o.out_push = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_push) out_valid_d = 1'b1;
  end

  // sequencer state: clearing pass, bucket walk, drain scan (read one entry, check it the next cycle)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cursor_q <= '0;
      scan_q <= '0;
      cnt_q <= '0;
      way_q <= '0;
      free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_CLEAR: begin
          scan_q <= scan_nx;
          if (scan_q == EntryW'(Entries - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            scan_q <= cursor_q;
            cnt_q <= '0;
            way_q <= '0;
            free_q <= (WayW+1)'(Ways);
            state_q <= req_type_i ? S_SCAN : S_MUL;
          end
        end
        S_MUL: state_q <= S_HASH;
        S_HASH: state_q <= S_READ;
        S_READ: state_q <= S_EVAL;
        S_EVAL: begin
          if (sts_i.hit || way_q == (WayW+1)'(Ways - 1)) begin
            state_q <= S_DONE;
          end else begin
            if (!sts_i.vld && free_q == (WayW+1)'(Ways)) free_q <= way_q;
            way_q <= way_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_SCAN: state_q <= S_SCHK;
        S_SCHK: begin
          if (sts_i.vld) begin
            cursor_q <= scan_nx;
            state_q <= S_DONE;
          end else if (cnt_q == EntryCntW'(Entries - 1)) begin
            state_q <= S_DONE;
          end else begin
            scan_q <= scan_nx;
            cnt_q <= cnt_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_DONE: begin
          if (cmd_o.out_push) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/tcp_flow_tracker_core.sv
// Top level of the TCP flow tracker: sequencer plus datapath.
// Packet: product, bucket, then read and compare way by way to a hit or the last of 4 ways.
// Drain: read and check entries from the cursor until a valid one or the whole table is checked.
// One item at a time; a waiting result sits in the output register while the next runs.
// Reset: async; then a clearing pass zeroes the valid bits, input held off.
module tcp_flow_tracker_core (
  input logic clk_i,
  input logic rst_ni,
  tft_if.sink   in_i,
  tft_if.source out_o
);
  import tft_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [EntryW-1:0] drain_idx;

  tft_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .req_type_i(in_i.data.req_type),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .sts_i(sts), .cmd_o(cmd),
    .drain_idx_o(drain_idx)
  );

  tft_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i(in_i.data), .cmd_i(cmd), .drain_idx_i(drain_idx),
    .sts_o(sts),
    .rsp_o(out_o.data)
  );

endmodule

// File: verif/tft_flow_checker.sv
// Watches both channels of the flow tracker, predicts each result word and compares.
`timescale 1ns / 100ps
module tft_flow_checker
  import tft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  logic                 flow_vld [Entries];
  entry_t               flow_tab [Entries];
  logic [EntryW-1:0]    drain_ptr;
  rsp_t                 expected_q [$];

  assign pending_o = expected_q.size();

  function automatic rsp_t record_of(logic [2:0] kind, int e);
    rsp_t r;
    r.out_kind       = kind;
    r.rec_src_ip     = flow_tab[e].src_ip;
    r.rec_dst_ip     = flow_tab[e].dst_ip;
    r.rec_src_port   = flow_tab[e].src_port;
    r.rec_dst_port   = flow_tab[e].dst_port;
    r.rec_up_bytes   = flow_tab[e].up_bytes;
    r.rec_down_bytes = flow_tab[e].down_bytes;
    r.rec_up_pkts    = flow_tab[e].up_pkts;
    r.rec_down_pkts  = flow_tab[e].down_pkts;
    r.rec_state      = flow_tab[e].conn_state;
    return r;
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  // track one packet or drain one flow; returns the word the block must emit
  function automatic rsp_t track_flow(req_t q);
    rsp_t        r;
    logic [31:0] mix;
    logic [15:0] h;
    int          base, free_way, e;
    logic        up, down;
    logic [2:0]  st;
    r = '0;
    if (q.req_type) begin
      for (int i = 0; i < Entries; i++) begin
        e = (int'(drain_ptr) + i) % Entries;
        if (flow_vld[e]) begin
          r = record_of(KIND_DRAINED, e);
          flow_vld[e] = 1'b0;
          drain_ptr = EntryW'((e + 1) % Entries);
          return r;
        end
      end
      r.out_kind = KIND_EMPTY;
      return r;
    end
    mix  = q.src_ip ^ q.dst_ip ^ 32'(q.src_port * q.dst_port);
    h    = (mix[15:0] & HashLoMask) ^ mix[31:16];
    base = (int'(h) % Buckets) * Ways;
    free_way = Ways;
    for (int w = 0; w < Ways; w++) begin
      e = base + w;
      if (!flow_vld[e]) begin
        if (free_way == Ways) free_way = w;
        continue;
      end
      up = flow_tab[e].src_ip == q.src_ip && flow_tab[e].dst_ip == q.dst_ip &&
           flow_tab[e].src_port == q.src_port && flow_tab[e].dst_port == q.dst_port;
      down = flow_tab[e].src_ip == q.dst_ip && flow_tab[e].dst_ip == q.src_ip &&
             flow_tab[e].src_port == q.dst_port && flow_tab[e].dst_port == q.src_port;
      if (!up && !down) continue;
      st = flow_tab[e].conn_state;
      if (up) begin
        flow_tab[e].up_bytes = add_sat(flow_tab[e].up_bytes, 32'(q.payload_len));
        flow_tab[e].up_pkts  = add_sat(flow_tab[e].up_pkts, 32'd1);
        if (st == ST_EST && q.fin_flag) st = ST_FW1;
        else if (st == ST_TW && q.ack_flag) st = ST_CLOSED;
        else if (st == ST_CW && q.fin_flag) st = ST_LA;
      end else begin
        flow_tab[e].down_bytes = add_sat(flow_tab[e].down_bytes, 32'(q.payload_len));
        flow_tab[e].down_pkts  = add_sat(flow_tab[e].down_pkts, 32'd1);
        if (st == ST_EST && q.fin_flag) st = ST_CW;
        else if (st == ST_LA && q.ack_flag) st = ST_CLOSED;
        else if (st == ST_FW1 && q.ack_flag) st = ST_FW2;
        else if (st == ST_FW2 && q.fin_flag) st = ST_TW;
      end
      flow_tab[e].conn_state = st;
      if (st == ST_CLOSED) begin
        r = record_of(KIND_CLOSED, e);
        flow_vld[e] = 1'b0;
      end else begin
        r = record_of(KIND_UPDATED, e);
      end
      return r;
    end
    if (free_way == Ways) begin
      r.out_kind     = KIND_FULL;
      r.rec_src_ip   = q.src_ip;
      r.rec_dst_ip   = q.dst_ip;
      r.rec_src_port = q.src_port;
      r.rec_dst_port = q.dst_port;
      return r;
    end
    e = base + free_way;
    flow_vld[e] = 1'b1;
    flow_tab[e] = '{src_ip: q.src_ip, dst_ip: q.dst_ip, src_port: q.src_port,
                    dst_port: q.dst_port, up_bytes: 32'(q.payload_len), down_bytes: '0,
                    up_pkts: 32'd1, down_pkts: '0, conn_state: ST_EST};
    return record_of(KIND_INSERTED, e);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_w;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) flow_vld[i] = 1'b0;
      drain_ptr  = '0;
      fail_cnt_o = 0;
      expected_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word kind=%0d", rsp_data_i.out_kind);
          fail_cnt_o++;
        end else begin
          exp_w = expected_q.pop_front();
          if (rsp_data_i !== exp_w) begin
            fail_cnt_o++;
            if (rsp_data_i.out_kind !== exp_w.out_kind)
              $error("out_kind exp %0d got %0d", exp_w.out_kind, rsp_data_i.out_kind);
            if (rsp_data_i.rec_src_ip !== exp_w.rec_src_ip)
              $error("rec_src_ip exp %h got %h", exp_w.rec_src_ip, rsp_data_i.rec_src_ip);
            if (rsp_data_i.rec_dst_ip !== exp_w.rec_dst_ip)
              $error("rec_dst_ip exp %h got %h", exp_w.rec_dst_ip, rsp_data_i.rec_dst_ip);
            if (rsp_data_i.rec_src_port !== exp_w.rec_src_port)
              $error("rec_src_port exp %h got %h", exp_w.rec_src_port,
                     rsp_data_i.rec_src_port);
            if (rsp_data_i.rec_dst_port !== exp_w.rec_dst_port)
              $error("rec_dst_port exp %h got %h", exp_w.rec_dst_port,
                     rsp_data_i.rec_dst_port);
            if (rsp_data_i.rec_up_bytes !== exp_w.rec_up_bytes)
              $error("rec_up_bytes exp %0d got %0d", exp_w.rec_up_bytes,
                     rsp_data_i.rec_up_bytes);
            if (rsp_data_i.rec_down_bytes !== exp_w.rec_down_bytes)
              $error("rec_down_bytes exp %0d got %0d", exp_w.rec_down_bytes,
                     rsp_data_i.rec_down_bytes);
            if (rsp_data_i.rec_up_pkts !== exp_w.rec_up_pkts)
              $error("rec_up_pkts exp %0d got %0d", exp_w.rec_up_pkts,
                     rsp_data_i.rec_up_pkts);
            if (rsp_data_i.rec_down_pkts !== exp_w.rec_down_pkts)
              $error("rec_down_pkts exp %0d got %0d", exp_w.rec_down_pkts,
                     rsp_data_i.rec_down_pkts);
            if (rsp_data_i.rec_state !== exp_w.rec_state)
              $error("rec_state exp %0d got %0d", exp_w.rec_state, rsp_data_i.rec_state);
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_q.push_back(track_flow(req_data_i));
    end
  end

endmodule

// File: verif/tb_tcp_flow_tracker_core.sv
// Stimulus and verdict for the TCP flow tracker core.
`timescale 1ns / 100ps
module tb_tcp_flow_tracker_core;
  import tft_pkg::*;

  typedef struct {
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
  } flow_t;

  logic        clk_i;
  logic        rst_ni;
  logic        calm;
  int unsigned fail_cnt, pending;
  flow_t       pool [20];

  tft_if #(.T(req_t)) req_ch ();
  tft_if #(.T(rsp_t)) rsp_ch ();

  tcp_flow_tracker_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  tft_flow_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_ch.valid),
    .req_ready_i(req_ch.ready),
    .req_data_i (req_ch.data),
    .rsp_valid_i(rsp_ch.valid),
    .rsp_ready_i(rsp_ch.ready),
    .rsp_data_i (rsp_ch.data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  // flow whose hash lands in the given bucket
  function automatic flow_t flow_in(logic [7:0] bucket);
    flow_t       f;
    logic [31:0] mix;
    f.sip = $urandom;
    f.sp  = 16'($urandom);
    f.dp  = 16'($urandom);
    mix   = $urandom;
    mix[7:0] = bucket ^ mix[23:16];
    f.dip = f.sip ^ mix ^ 32'(f.sp * f.dp);
    return f;
  endfunction

  function automatic req_t pkt(flow_t f, bit rev, logic [15:0] len, bit fin, bit ack);
    req_t q;
    q.req_type    = 1'b0;
    q.src_ip      = rev ? f.dip : f.sip;
    q.dst_ip      = rev ? f.sip : f.dip;
    q.src_port    = rev ? f.dp : f.sp;
    q.dst_port    = rev ? f.sp : f.dp;
    q.payload_len = len;
    q.fin_flag    = fin;
    q.ack_flag    = ack;
    return q;
  endfunction

  task automatic send(req_t q);
    while (!calm && $urandom_range(99) < 32) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= q;
    do @(negedge clk_i); while (!req_ch.ready);
    @(posedge clk_i);
  endtask

  task automatic drain();
    req_t q;
    q = '0;
    q.req_type = 1'b1;
    q.src_ip   = $urandom;
    send(q);
  endtask

  initial begin
    flow_t f, g;
    req_t  q;
    int    k;
    rst_ni       = 1'b0;
    calm         = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty drain, extreme tuples, both teardown orders, full bucket
    drain();
    f = '{32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff};
    send(pkt(f, 1'b0, 16'hffff, 1'b1, 1'b1));
    f = '{32'h0, 32'h0, 16'h0, 16'h0};
    send(pkt(f, 1'b0, 16'h0, 1'b0, 1'b0));
    f = flow_in(8'h11);
    send(pkt(f, 1'b0, 16'd100, 1'b0, 1'b0));
    send(pkt(f, 1'b0, 16'd5, 1'b1, 1'b0));    // active close
    send(pkt(f, 1'b1, 16'd7, 1'b0, 1'b1));
    send(pkt(f, 1'b1, 16'hffff, 1'b1, 1'b0));
    send(pkt(f, 1'b0, 16'd0, 1'b0, 1'b1));    // closes
    g = flow_in(8'h22);
    send(pkt(g, 1'b1, 16'd3, 1'b0, 1'b1));
    send(pkt(g, 1'b0, 16'd9, 1'b1, 1'b1));    // originator is the reverse side here
    send(pkt(g, 1'b1, 16'd1, 1'b1, 1'b0));
    send(pkt(g, 1'b0, 16'd2, 1'b0, 1'b1));
    for (int i = 0; i < 5; i++) begin
      pool[i] = flow_in(8'h33);
      send(pkt(pool[i], 1'b0, 16'(i), 1'b0, 1'b0));
    end
    repeat (4) drain();

    // random part: mostly teardown traffic over flows packed into few buckets
    for (int i = 0; i < 20; i++) pool[i] = flow_in(8'(i % 4));
    for (int n = 0; n < 1300; n++) begin
      if (n == 300) calm = 1'b1;
      if (n == 450) calm = 1'b0;
      if (n == 700) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      k = $urandom_range(99);
      if (k < 6) drain();
      else if (k < 16) begin
        q = req_t'({$urandom, $urandom, $urandom, $urandom});
        q.req_type = 1'b0;
        send(q);
      end else begin
        if (k < 19) pool[$urandom_range(19)] = flow_in(8'($urandom_range(7)));
        f = pool[$urandom_range(19)];
        send(pkt(f, 1'($urandom_range(1)),
                 $urandom_range(9) == 0 ? 16'hffff : 16'($urandom),
                 $urandom_range(99) < 30, $urandom_range(99) < 50));
      end
    end
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (1100) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: tcp_flow_tracker_core.f
sv/tft_pkg.sv
sv/tft_if.sv
sv/tft_datapath.sv
sv/tft_ctrl.sv
sv/tcp_flow_tracker_core.sv
verif/tft_flow_checker.sv
verif/tb_tcp_flow_tracker_core.sv
